@@ src/lage_pkg.sv @@
// ----------------------------------------------------------------------------
// lage_pkg
// Shared types and constants for the life generation engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lage_pkg;

	localparam int unsigned GRID_SIDE_DEF = 64;
	localparam int unsigned ADDR_W        = 6;
	localparam int unsigned CMD_W         = 3;
	localparam int unsigned GEN_W         = 32;
	localparam int unsigned NBR_W         = 4;

	// B3/S23
	localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET    = 3'd0,
		CMD_TOGGLE = 3'd1,
		CMD_READ   = 3'd2,
		CMD_STEP   = 3'd3,
		CMD_INVERT = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	// operation broadcast to every row cell
	typedef struct packed {
		logic shift;
		logic clear;
		logic invert;
		logic write;
		logic toggle;
	} cell_op_t;

endpackage

`default_nettype wire

@@ src/lage_cell.sv @@
// ----------------------------------------------------------------------------
// lage_cell
// One grid row in the ring of row cells; local edits or shift to neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lage_cell #(
	parameter int unsigned WIDTH = lage_pkg::GRID_SIDE_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  lage_pkg::cell_op_t    op,
	input  wire logic             sel,
	input  wire logic [WIDTH-1:0] wmask,
	input  wire logic             wval,
	input  wire logic [WIDTH-1:0] shift_in,
	output logic      [WIDTH-1:0] bits
);
	import lage_pkg::*;

	logic [WIDTH-1:0] bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (op.shift) begin
			bits_q <= shift_in;
		end else if (op.clear) begin
			bits_q <= '0;
		end else if (op.invert) begin
			bits_q <= ~bits_q;
		end else if (op.write && sel) begin
			bits_q <= wval ? (bits_q | wmask) : (bits_q & ~wmask);
		end else if (op.toggle && sel) begin
			bits_q <= bits_q ^ wmask;
		end
	end

	assign bits = bits_q;

endmodule

`default_nettype wire

@@ src/lage_rule.sv @@
// ----------------------------------------------------------------------------
// lage_rule
// Next-generation row from the rows above, current and below (dead border).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lage_rule #(
	parameter int unsigned WIDTH = lage_pkg::GRID_SIDE_DEF
) (
	input  wire logic [WIDTH-1:0] above,
	input  wire logic [WIDTH-1:0] cur,
	input  wire logic [WIDTH-1:0] below,
	output logic      [WIDTH-1:0] next
);
	import lage_pkg::*;

	logic [WIDTH+1:0] a_p, c_p, b_p;
	logic [NBR_W-1:0] n;

	always_comb begin
		// pad with dead cells on both sides
		a_p = {1'b0, above, 1'b0};
		c_p = {1'b0, cur, 1'b0};
		b_p = {1'b0, below, 1'b0};
		next = '0;
		n    = '0;
		for (int c = 0; c < WIDTH; c++) begin
			n = NBR_W'(a_p[c]) + NBR_W'(a_p[c+1]) + NBR_W'(a_p[c+2])
			  + NBR_W'(c_p[c]) + NBR_W'(c_p[c+2])
			  + NBR_W'(b_p[c]) + NBR_W'(b_p[c+1]) + NBR_W'(b_p[c+2]);
			next[c] = (n == BIRTH_COUNT) || (cur[c] && (n == SURVIVE_COUNT));
		end
	end

endmodule

`default_nettype wire

@@ src/life_automaton_generation_engine_unit.sv @@
// ----------------------------------------------------------------------------
// life_automaton_generation_engine_unit
// Game of Life (B3/S23) engine over a bounded square grid held in a row ring.
// ----------------------------------------------------------------------------
// The grid lives in a ring of GRID_SIDE row cells. Set, toggle, read, invert,
// clear and unused codes have their result registered at the edge that
// accepts the transaction. A step rotates the ring once through the rule
// unit, one row per cycle, but the final rotation waits while a result is
// held at the output by out_stall. The next command is taken once the step
// has finished; a result held at the output by out_stall also holds off the
// next command.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_generation_engine_unit #(
	parameter int unsigned GRID_SIDE = lage_pkg::GRID_SIDE_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lage_pkg::CMD_W-1:0]  command,
	input  wire logic [lage_pkg::ADDR_W-1:0] column,
	input  wire logic [lage_pkg::ADDR_W-1:0] row,
	input  wire logic                        cell_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             cell_alive,
	output logic      [lage_pkg::GEN_W-1:0]  generation
);
	import lage_pkg::*;

	localparam int unsigned CW   = $clog2(GRID_SIDE);
	localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_STEP = 2'b10
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        k_q;
	logic [GRID_SIDE-1:0] above_q;
	logic [GEN_W-1:0]     gen_q;
	logic                 out_valid_q;
	logic                 cell_alive_q;
	logic [GEN_W-1:0]     generation_q;

	logic [GRID_SIDE-1:0] rows  [GRID_SIDE];
	logic [GRID_SIDE-1:0] sel;
	logic [GRID_SIDE-1:0] row_bits;
	logic [GRID_SIDE-1:0] wmask;
	logic [GRID_SIDE-1:0] below;
	logic [GRID_SIDE-1:0] new_row;
	logic [CW-1:0]        col_idx;
	cmd_t                 cmd;
	cell_op_t             op;
	logic                 accept;
	logic                 in_grid;
	logic                 out_free;
	logic                 step_done;
	logic                 old_bit;
	logic                 alive_n;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign cmd      = cmd_t'(command);
	assign col_idx  = column[CW-1:0];
	assign in_grid  = (32'(column) < GRID_SIDE) && (32'(row) < GRID_SIDE);
	assign wmask    = GRID_SIDE'(1) << col_idx;
	assign step_done = (state_q == ST_STEP) && (k_q == LAST) && out_free;
	// last row of a step sees dead cells below
	assign below    = (k_q == LAST) ? '0 : rows[1];

	always_comb begin
		for (int i = 0; i < GRID_SIDE; i++) begin
			sel[i] = in_grid && (row == ADDR_W'(i));
		end
		row_bits = '0;
		for (int i = 0; i < GRID_SIDE; i++) begin
			row_bits = row_bits | (sel[i] ? rows[i] : '0);
		end
		old_bit = in_grid && row_bits[col_idx];
	end

	always_comb begin
		op      = '0;
		alive_n = 1'b0;
		if (accept) begin
			case (cmd)
				CMD_SET: begin
					op.write = in_grid;
					alive_n  = in_grid && cell_value;
				end
				CMD_TOGGLE: begin
					op.toggle = in_grid;
					alive_n   = in_grid && !old_bit;
				end
				CMD_READ: begin
					alive_n = old_bit;
				end
				CMD_INVERT: op.invert = 1'b1;
				CMD_CLEAR:  op.clear  = 1'b1;
				default:    alive_n   = 1'b0;
			endcase
		end
		// hold the final rotation until the result can be registered
		if ((state_q == ST_STEP) && ((k_q != LAST) || out_free)) begin
			op.shift = 1'b1;
		end
	end

	lage_rule #(
		.WIDTH (GRID_SIDE)
	) u_rule (
		.above (above_q),
		.cur   (rows[0]),
		.below (below),
		.next  (new_row)
	);

	for (genvar i = 0; i < GRID_SIDE; i++) begin : g_cell
		logic [GRID_SIDE-1:0] shift_in;
		if (i == GRID_SIDE - 1) begin : g_tail
			assign shift_in = new_row;
		end else begin : g_body
			assign shift_in = rows[i+1];
		end
		lage_cell #(
			.WIDTH (GRID_SIDE)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.sel      (sel[i]),
			.wmask    (wmask),
			.wval     (cell_value),
			.shift_in (shift_in),
			.bits     (rows[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			above_q     <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_STEP)) begin
						state_q <= ST_STEP;
						k_q     <= '0;
						above_q <= '0;
					end else if (accept && ((cmd == CMD_INVERT) || (cmd == CMD_CLEAR))) begin
						gen_q <= '0;
					end
				end
				ST_STEP: begin
					if (op.shift) begin
						above_q <= rows[0];
						k_q     <= k_q + CW'(1);
					end
					if (step_done) begin
						state_q <= ST_IDLE;
						gen_q   <= gen_q + GEN_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if ((accept && (cmd != CMD_STEP)) || step_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step_done) begin
			cell_alive_q <= 1'b0;
			generation_q <= gen_q + GEN_W'(1);
		end else if (accept && (cmd != CMD_STEP)) begin
			cell_alive_q <= alive_n;
			if ((cmd == CMD_INVERT) || (cmd == CMD_CLEAR)) begin
				generation_q <= '0;
			end else begin
				generation_q <= gen_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_alive = cell_alive_q;
	assign generation = generation_q;

endmodule

`default_nettype wire
